FILE: sv/hpc_pkg.sv
// hpc_pkg: shared types and constants for the hyperedge pin coarsening block.
// No dependencies.
package hpc_pkg;

    localparam int NODE_W  = 12;
    localparam int GROUP_W = 12;
    localparam int CNT_W   = 6;
    localparam int STAMP_W = 16;

    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_PIN  = 1'b1;

    // one classified item passed from front to back
    typedef struct packed {
        logic               action;
        logic [NODE_W-1:0]  node_id;
        logic [GROUP_W-1:0] map_grp;
        logic               is_dst;
        logic               last_pin;
    } item_t;

endpackage

FILE: sv/hpc_front.sv
// hpc_front: input stage and two-entry queue toward the back end.
// Depends on hpc_pkg.
module hpc_front (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  hpc_pkg::item_t s_item,
    output logic           q_valid,
    input  logic           q_ready,
    output hpc_pkg::item_t q_item
);

    hpc_pkg::item_t mem_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    logic       push, pop;

    assign s_ready = (cnt_reg != 2'd2);
    assign q_valid = (cnt_reg != 2'd0);
    assign q_item  = mem_reg[rp_reg];
    assign push    = s_valid && s_ready;
    assign pop     = q_valid && q_ready;

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wp_reg] <= s_item;
        end
        if (!aresetn) begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            if (push) wp_reg <= ~wp_reg;
            if (pop) rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

endmodule

FILE: sv/hpc_back.sv
// hpc_back: map and stamp memories, pin buffers, sort and emit sequencer.
// Depends on hpc_pkg.
module hpc_back #(
    parameter int NODE_COUNT  = 4096,
    parameter int GROUP_COUNT = 4096,
    parameter int MAX_PINS    = 32,
    parameter int MAX_HEDGES  = 65535
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        q_valid,
    output logic                        q_ready,
    input  hpc_pkg::item_t              q_item,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [hpc_pkg::GROUP_W-1:0] m_out_group,
    output logic                        m_out_is_src,
    output logic [hpc_pkg::CNT_W-1:0]   m_src_count,
    output logic                        m_overflow,
    output logic                        m_out_last
);

    localparam int NW = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
    localparam int GW = (GROUP_COUNT > 1) ? $clog2(GROUP_COUNT) : 1;
    localparam int PW = $clog2(MAX_PINS);
    localparam int FW = PW + 1;
    localparam logic [hpc_pkg::STAMP_W-1:0] STAMP_NONE = '1;

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_LOOK  = 3'd2;
    localparam logic [2:0] ST_STAMP = 3'd3;
    localparam logic [2:0] ST_SORT  = 3'd4;
    localparam logic [2:0] ST_EMIT  = 3'd5;

    logic [hpc_pkg::GROUP_W-1:0] map_mem [NODE_COUNT];
    logic [hpc_pkg::STAMP_W-1:0] stamp_mem [GROUP_COUNT];
    logic [hpc_pkg::GROUP_W-1:0] src_buf [MAX_PINS];
    logic [hpc_pkg::GROUP_W-1:0] dst_buf [MAX_PINS];

    logic [2:0]                  st_reg;
    logic [GW-1:0]               clr_reg;
    logic [hpc_pkg::STAMP_W-1:0] hc_reg;
    logic [FW-1:0]               sf_reg, df_reg;
    logic                        ovf_reg;
    hpc_pkg::item_t              it_reg;
    logic [hpc_pkg::GROUP_W-1:0] grp_rd_reg;
    logic [hpc_pkg::STAMP_W-1:0] stamp_rd_reg;
    logic [FW-1:0]               si_reg, sj_reg, k_reg;
    logic [FW:0]                 tot;
    logic                        wrap;

    // out register
    logic                        ov_reg;
    logic [hpc_pkg::GROUP_W-1:0] og_reg;
    logic                        os_reg, ol_reg, oo_reg;
    logic [hpc_pkg::CNT_W-1:0]   oc_reg;

    logic node_ok, grp_ok, out_free, emit_fire;
    logic [hpc_pkg::GROUP_W-1:0] dj, dj1;

    assign node_ok   = {{(32-hpc_pkg::NODE_W){1'b0}}, it_reg.node_id} < NODE_COUNT;
    assign grp_ok    = {{(32-hpc_pkg::GROUP_W){1'b0}}, grp_rd_reg} < GROUP_COUNT;
    assign out_free  = !ov_reg || m_ready;
    assign emit_fire = (st_reg == ST_EMIT) && out_free && ({1'b0, k_reg} < tot);
    assign q_ready   = (st_reg == ST_IDLE);
    assign tot       = {1'b0, sf_reg} + {1'b0, df_reg};
    assign wrap      = ({16'd0, hc_reg} + 32'd1) >= MAX_HEDGES;
    assign dj        = dst_buf[sj_reg[PW-1:0]];
    assign dj1       = dst_buf[sj_reg[PW-1:0] - 1'b1];

    assign m_valid      = ov_reg;
    assign m_out_group  = og_reg;
    assign m_out_is_src = os_reg;
    assign m_src_count  = oc_reg;
    assign m_overflow   = oo_reg;
    assign m_out_last   = ol_reg;

    // map load and lookup (registered read, held until the next accepted item)
    always_ff @(posedge aclk) begin
        if (q_valid && q_ready) begin
            if (q_item.action == hpc_pkg::ACT_LOAD
                    && {{(32-hpc_pkg::NODE_W){1'b0}}, q_item.node_id} < NODE_COUNT) begin
                map_mem[NW'(q_item.node_id)] <= q_item.map_grp;
            end
            grp_rd_reg <= map_mem[NW'(q_item.node_id)];
        end
    end

    // stamp memory: read in LOOK, write in STAMP or clearing pass
    always_ff @(posedge aclk) begin
        if (st_reg == ST_CLEAR) begin
            stamp_mem[clr_reg] <= STAMP_NONE;
        end else if (st_reg == ST_STAMP && node_ok && grp_ok && stamp_rd_reg != hc_reg) begin
            stamp_mem[GW'(grp_rd_reg)] <= hc_reg;
        end
        stamp_rd_reg <= stamp_mem[GW'(grp_rd_reg)];
    end

    always_ff @(posedge aclk) begin
        if (st_reg == ST_IDLE && q_valid) begin
            it_reg <= q_item;
        end
        if (st_reg == ST_STAMP && node_ok && grp_ok && stamp_rd_reg != hc_reg
                && tot < (FW+1)'(MAX_PINS)) begin
            if (it_reg.is_dst) dst_buf[df_reg[PW-1:0]] <= grp_rd_reg;
            else src_buf[sf_reg[PW-1:0]] <= grp_rd_reg;
        end
        // insertion sort, one compare/shift per cycle
        if (st_reg == ST_SORT && si_reg < df_reg) begin
            if (sj_reg != '0 && dj1 < dj) begin
                dst_buf[sj_reg[PW-1:0]]        <= dj1;
                dst_buf[sj_reg[PW-1:0] - 1'b1] <= dj;
            end
        end
        if (emit_fire) begin
            if (k_reg < sf_reg) begin
                og_reg <= src_buf[k_reg[PW-1:0]];
                os_reg <= 1'b1;
            end else begin
                og_reg <= dst_buf[PW'(k_reg - sf_reg)];
                os_reg <= 1'b0;
            end
            oc_reg <= hpc_pkg::CNT_W'(sf_reg);
            oo_reg <= ovf_reg;
            ol_reg <= ({1'b0, k_reg} + 1'b1) == tot;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg  <= ST_CLEAR;
            clr_reg <= '0;
            hc_reg  <= '0;
            sf_reg  <= '0;
            df_reg  <= '0;
            ovf_reg <= 1'b0;
            si_reg  <= '0;
            sj_reg  <= '0;
            k_reg   <= '0;
            ov_reg  <= 1'b0;
        end else begin
            if (emit_fire) ov_reg <= 1'b1;
            else if (m_ready) ov_reg <= 1'b0;
            case (st_reg)
                ST_CLEAR: begin
                    clr_reg <= clr_reg + 1'b1;
                    if ({{(32-GW){1'b0}}, clr_reg} == GROUP_COUNT - 1) begin
                        clr_reg <= '0;
                        st_reg  <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (q_valid && q_item.action == hpc_pkg::ACT_PIN) st_reg <= ST_LOOK;
                end
                ST_LOOK: st_reg <= ST_STAMP;
                ST_STAMP: begin
                    if (node_ok && grp_ok && stamp_rd_reg != hc_reg) begin
                        if (tot >= (FW+1)'(MAX_PINS)) ovf_reg <= 1'b1;
                        else if (it_reg.is_dst) df_reg <= df_reg + 1'b1;
                        else sf_reg <= sf_reg + 1'b1;
                    end
                    if (it_reg.last_pin) begin
                        st_reg <= ST_SORT;
                        si_reg <= FW'(1);
                        sj_reg <= FW'(1);
                    end else begin
                        st_reg <= ST_IDLE;
                    end
                end
                ST_SORT: begin
                    if (si_reg >= df_reg) begin
                        st_reg <= ST_EMIT;
                        k_reg  <= '0;
                    end else if (sj_reg != '0 && dj1 < dj) begin
                        sj_reg <= sj_reg - 1'b1;
                    end else begin
                        si_reg <= si_reg + 1'b1;
                        sj_reg <= si_reg + 1'b1;
                    end
                end
                ST_EMIT: begin
                    if ({1'b0, k_reg} >= tot) begin
                        sf_reg  <= '0;
                        df_reg  <= '0;
                        ovf_reg <= 1'b0;
                        if (wrap) begin
                            hc_reg <= '0;
                            st_reg <= ST_CLEAR;
                        end else begin
                            hc_reg <= hc_reg + 1'b1;
                            st_reg <= ST_IDLE;
                        end
                    end else if (out_free) begin
                        k_reg <= k_reg + 1'b1;
                    end
                end
                default: st_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

FILE: sv/hyperedge_pin_coarsening_core.sv
// hyperedge_pin_coarsening_core: top level, front queue plus back sequencer.
// Depends on hpc_pkg, hpc_front, hpc_back.
//
// Usage: s_ channel carries load items (action 0: node_id -> s_map_grp) and
// pin items (action 1), destinations first then sources, last_pin on the
// final pin of a hyperedge. The m_ channel returns distinct sources in
// arrival order, then distinct destinations descending; out_last marks the
// final result. Empty hyperedges give nothing.
// Throughput: loads are taken back to back while the back end is idle; a pin
// passes through map read, stamp read and stamp write on the single stamp
// port before the next item is taken. On the last pin the destinations are
// insertion sorted and the results emitted, via LOOK, STAMP, SORT and EMIT.
// A two-entry queue keeps accepting, until full, while the back end works.
// After reset, and whenever the hyperedge counter wraps, a clearing pass
// over all GROUP_COUNT stamp entries resets them; no items are processed
// meanwhile. A stalled m_ready holds the result register and the sequencer
// waits.
module hyperedge_pin_coarsening_core #(
    parameter int NODE_COUNT  = 4096,
    parameter int GROUP_COUNT = 4096,
    parameter int MAX_PINS    = 32,
    parameter int MAX_HEDGES  = 65535
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_action,
    input  logic [11:0] s_node_id,
    input  logic [11:0] s_map_grp,
    input  logic        s_is_dst,
    input  logic        s_last_pin,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [11:0] m_out_group,
    output logic        m_out_is_src,
    output logic [5:0]  m_src_count,
    output logic        m_overflow,
    output logic        m_out_last
);

    hpc_pkg::item_t s_item, q_item;
    logic           q_valid, q_ready;

    assign s_item = '{action: s_action, node_id: s_node_id, map_grp: s_map_grp,
                      is_dst: s_is_dst, last_pin: s_last_pin};

    hpc_front u_front (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_item(s_item),
        .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item)
    );

    hpc_back #(
        .NODE_COUNT(NODE_COUNT), .GROUP_COUNT(GROUP_COUNT),
        .MAX_PINS(MAX_PINS), .MAX_HEDGES(MAX_HEDGES)
    ) u_back (
        .aclk(aclk), .aresetn(aresetn),
        .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_out_group(m_out_group), .m_out_is_src(m_out_is_src),
        .m_src_count(m_src_count), .m_overflow(m_overflow),
        .m_out_last(m_out_last)
    );

`ifndef NO_ASSERTIONS
    a_src_le_max: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_src_count <= 6'(MAX_PINS))
        else $error("src_count above buffer size");
    a_src_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_out_is_src |-> m_src_count != 6'd0)
        else $error("source result with zero source count");
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_out_group))
        else $error("result changed while stalled");
`endif

endmodule

FILE: tb/hpc_checker.sv
// hpc_checker: watches the s_ and m_ channels of the pin coarsening block,
// predicts coarse pins per hyperedge and compares. Depends on hpc_pkg.
module hpc_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic        s_action,
    input  logic [11:0] s_node_id,
    input  logic [11:0] s_map_grp,
    input  logic        s_is_dst,
    input  logic        s_last_pin,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [11:0] m_out_group,
    input  logic        m_out_is_src,
    input  logic [5:0]  m_src_count,
    input  logic        m_overflow,
    input  logic        m_out_last,
    output int          fail_count,
    output int          pending
);

    localparam int NGROUPS  = 4096;
    localparam int PIN_SLOTS = 32;
    localparam int HEDGE_WRAP = 65535;

    typedef struct packed {
        logic [11:0] grp;
        logic        is_src;
        logic [5:0]  nsrc;
        logic        ovf;
        logic        last;
    } coarse_pin_t;

    coarse_pin_t        coarse_q[$];
    logic [11:0]        node_group[int];
    logic [15:0]        stamp[NGROUPS];
    logic [15:0]        hedge_no;
    logic [11:0]        srcs[$];
    logic [11:0]        dsts[$];
    logic               dropped;

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
        fail_count++;
    endtask

    task automatic coarsen(input logic [11:0] node, input logic dst, input logic last);
        logic [11:0] g;
        logic [11:0] sorted[$];
        coarse_pin_t cp;
        int total;
        g = node_group.exists(node) ? node_group[node] : 12'd0;
        if (stamp[g] != hedge_no) begin
            stamp[g] = hedge_no;
            if (srcs.size() + dsts.size() >= PIN_SLOTS) dropped = 1'b1;
            else if (dst) dsts.insert(dsts.size(), g);
            else srcs.insert(srcs.size(), g);
        end
        if (!last) return;
        sorted = dsts;
        sorted.rsort();
        total = srcs.size() + sorted.size();
        for (int k = 0; k < total; k++) begin
            cp.is_src = k < srcs.size();
            cp.grp = cp.is_src ? srcs[k] : sorted[k - srcs.size()];
            cp.nsrc = 6'(srcs.size());
            cp.ovf = dropped;
            cp.last = (k + 1 == total);
            coarse_q.insert(coarse_q.size(), cp);
        end
        srcs.delete();
        dsts.delete();
        dropped = 1'b0;
        if (32'(hedge_no) + 1 >= HEDGE_WRAP) begin
            hedge_no = '0;
            foreach (stamp[i]) stamp[i] = '1;
        end else begin
            hedge_no++;
        end
    endtask

    initial begin
        fail_count = 0;
        pending = 0;
        hedge_no = '0;
        dropped = 1'b0;
        foreach (stamp[i]) stamp[i] = '1;
    end

    always @(posedge aclk) begin
        coarse_pin_t want;
        if (aresetn && s_valid && s_ready) begin
            if (s_action == hpc_pkg::ACT_LOAD) node_group[s_node_id] = s_map_grp;
            else coarsen(s_node_id, s_is_dst, s_last_pin);
        end
        if (aresetn && m_valid && m_ready) begin
            if (coarse_q.size() == 0) begin
                report("unexpected item", 32'(m_out_group), 32'd0);
            end else begin
                want = coarse_q.pop_front();
                if (m_out_group != want.grp)
                    report("out_group", 32'(m_out_group), 32'(want.grp));
                if (m_out_is_src != want.is_src)
                    report("out_is_src", 32'(m_out_is_src), 32'(want.is_src));
                if (m_src_count != want.nsrc)
                    report("src_count", 32'(m_src_count), 32'(want.nsrc));
                if (m_overflow != want.ovf)
                    report("overflow", 32'(m_overflow), 32'(want.ovf));
                if (m_out_last != want.last)
                    report("out_last", 32'(m_out_last), 32'(want.last));
            end
        end
        pending = coarse_q.size();
    end
endmodule

FILE: tb/hyperedge_pin_coarsening_core_test.sv
// hyperedge_pin_coarsening_core_test: stimulus and verdict for the coarsening
// block. Depends on hpc_pkg, hyperedge_pin_coarsening_core and hpc_checker.
module hyperedge_pin_coarsening_core_test;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic        s_action;
    logic [11:0] s_node_id;
    logic [11:0] s_map_grp;
    logic        s_is_dst;
    logic        s_last_pin;
    logic        m_valid;
    logic        m_ready;
    logic [11:0] m_out_group;
    logic        m_out_is_src;
    logic [5:0]  m_src_count;
    logic        m_overflow;
    logic        m_out_last;
    int          fail_count;
    int          pending;
    int          cycles;
    bit          hold_off;
    logic [11:0] loaded[$];

    hyperedge_pin_coarsening_core dut (.*);

    hpc_checker checker_i (.*);

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    initial begin
        cycles = 0;
        forever begin
            @(posedge aclk);
            cycles++;
            if (cycles > 2000000) begin
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // receiver: random stalls, plus one long hold-off
    initial begin
        int n;
        m_ready = 1'b0;
        @(posedge aclk iff aresetn);
        forever begin
            if (hold_off) begin
                m_ready <= 1'b0;
                repeat (600) @(posedge aclk);
                hold_off = 1'b0;
            end
            n = ($urandom_range(0, 3) == 0) ? gap_len() : 0;
            if (n > 0) begin
                m_ready <= 1'b0;
                repeat (n) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
        end
    end

    task automatic send(input logic act, input logic [11:0] node, input logic [11:0] grp,
                        input logic dst, input logic last);
        int n;
        n = gap_len();
        if (n > 0) begin
            s_valid <= 1'b0;
            repeat (n) @(posedge aclk);
        end
        s_valid    <= 1'b1;
        s_action   <= act;
        s_node_id  <= node;
        s_map_grp  <= grp;
        s_is_dst   <= dst;
        s_last_pin <= last;
        @(posedge aclk iff s_ready);
    endtask

    task automatic load(input logic [11:0] node, input logic [11:0] grp);
        send(hpc_pkg::ACT_LOAD, node, grp, 1'($urandom_range(0, 1)),
             1'($urandom_range(0, 1)));
        loaded.insert(loaded.size(), node);
    endtask

    function automatic logic [11:0] any_loaded();
        return loaded[$urandom_range(0, loaded.size() - 1)];
    endfunction

    // destinations then sources of one hyperedge, from loaded nodes
    task automatic hedge(input int ndst, input int nsrc);
        for (int i = 0; i < ndst; i++)
            send(hpc_pkg::ACT_PIN, any_loaded(), 12'($urandom), 1'b1,
                 (i == ndst - 1) && nsrc == 0);
        for (int i = 0; i < nsrc; i++)
            send(hpc_pkg::ACT_PIN, any_loaded(), 12'($urandom), 1'b0, i == nsrc - 1);
    endtask

    initial begin
        int k;
        s_valid = 1'b0; s_action = 1'b0; s_node_id = '0; s_map_grp = '0;
        s_is_dst = 1'b0; s_last_pin = 1'b0;
        hold_off = 1'b0;
        aresetn = 1'b0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: extremes, self-cycle, source before destination
        load(12'd0, 12'hfff);
        load(12'hfff, 12'd0);
        load(12'd5, 12'hfff);
        load(12'd6, 12'h555);
        load(12'd7, 12'haaa);
        send(hpc_pkg::ACT_PIN, 12'd0, 12'd0, 1'b1, 1'b0);
        send(hpc_pkg::ACT_PIN, 12'd6, 12'd0, 1'b1, 1'b0);
        send(hpc_pkg::ACT_PIN, 12'd5, 12'd0, 1'b0, 1'b0);
        send(hpc_pkg::ACT_PIN, 12'hfff, 12'd0, 1'b0, 1'b1);
        send(hpc_pkg::ACT_PIN, 12'd7, 12'd0, 1'b0, 1'b0);
        send(hpc_pkg::ACT_PIN, 12'd7, 12'd0, 1'b1, 1'b0);
        send(hpc_pkg::ACT_PIN, 12'd6, 12'd0, 1'b1, 1'b1);
        send(hpc_pkg::ACT_PIN, 12'd0, 12'd0, 1'b1, 1'b1);

        for (k = 0; k < 60; k++) load(12'($urandom), 12'($urandom_range(0, 63)));
        // overflow: many distinct groups in one hyperedge
        for (k = 0; k < 40; k++) load(12'(100 + k), 12'(3000 + k));
        for (k = 0; k < 40; k++)
            send(hpc_pkg::ACT_PIN, 12'(100 + k), 12'd0, k < 20, k == 39);

        hold_off = 1'b1;
        k = 0;
        while (k < 140) begin
            if ($urandom_range(0, 9) == 0) begin
                load(12'($urandom), 12'($urandom_range(0, 4095)));
                k++;
            end else begin
                int nd, ns;
                nd = $urandom_range(0, 4);
                ns = $urandom_range(nd == 0 ? 1 : 0, 4);
                hedge(nd, ns);
                k += nd + ns;
            end
        end

        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
        if (fail_count == 0 && pending == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule
